### rtl/mbs_pkg.sv
// Shared types, constants and the control program of the median-by-sorting block.
package mbs_pkg;

    localparam int unsigned MAX_ITEMS_DEF = 128;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned PC_W          = 4;

    typedef logic [PC_W-1:0] pc_t;

    // Program step addresses
    localparam pc_t PC_LOAD    = 4'd0;
    localparam pc_t PC_PASS    = 4'd1;
    localparam pc_t PC_PRIME   = 4'd2;
    localparam pc_t PC_INNER   = 4'd3;
    localparam pc_t PC_FIN     = 4'd4;
    localparam pc_t PC_MED_A   = 4'd5;
    localparam pc_t PC_MED_B   = 4'd6;
    localparam pc_t PC_MED_OUT = 4'd7;
    localparam pc_t PC_BACK    = 4'd8;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_ONE,
        RD_NEXT,
        RD_LOWER,
        RD_MID
    } rd_sel_t;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_NOT_LAST,
        JC_LIM_LT2,
        JC_MORE,
        JC_OUT_BUSY
    } jcond_t;

    typedef struct packed {
        logic    load_en;
        logic    k_clr;
        logic    carry_ld;
        logic    sort_step;
        logic    pass_end;
        logic    med_first;
        logic    med_out;
        rd_sel_t rd_sel;
        jcond_t  jc;
        pc_t     target;
    } ucode_t;

    typedef struct packed {
        logic beat_last;
        logic lim_lt2;
        logic more;
        logic out_busy;
    } seq_status_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        w        = '0;
        w.rd_sel = RD_ZERO;
        w.jc     = JC_NONE;
        w.target = PC_LOAD;
        case (pc)
            PC_LOAD: begin
                w.load_en = 1'b1;
                w.jc      = JC_NOT_LAST;
                w.target  = PC_LOAD;
            end
            PC_PASS: begin
                w.k_clr  = 1'b1;
                w.rd_sel = RD_ZERO;
                w.jc     = JC_LIM_LT2;
                w.target = PC_MED_A;
            end
            PC_PRIME: begin
                w.carry_ld = 1'b1;
                w.rd_sel   = RD_ONE;
            end
            PC_INNER: begin
                w.sort_step = 1'b1;
                w.rd_sel    = RD_NEXT;
                w.jc        = JC_MORE;
                w.target    = PC_INNER;
            end
            PC_FIN: begin
                w.pass_end = 1'b1;
                w.jc       = JC_ALWAYS;
                w.target   = PC_PASS;
            end
            PC_MED_A: begin
                w.rd_sel = RD_LOWER;
            end
            PC_MED_B: begin
                w.med_first = 1'b1;
                w.rd_sel    = RD_MID;
            end
            PC_MED_OUT: begin
                w.med_out = 1'b1;
                w.rd_sel  = RD_MID;
                w.jc      = JC_OUT_BUSY;
                w.target  = PC_MED_OUT;
            end
            PC_BACK: begin
                w.jc     = JC_ALWAYS;
                w.target = PC_LOAD;
            end
            default: begin
                w.jc     = JC_ALWAYS;
                w.target = PC_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/median_by_sorting.sv
// Median by bubble sort: load a set of signed words, sort in place, emit the median.
//
// Elements load one beat per cycle until the beat with tlast; up to MAX_ITEMS are
// kept and any further ones are dropped and flagged on m_tuser. The set is then
// bubble sorted in the element memory, one compare-and-write per cycle through its
// single read and single write port, with a running maximum held in a register.
// The median is then formed and, once no earlier result still waits on m_tready,
// loaded into the output register; the block then returns to loading.
// s_tready is low from the closing beat until the sequencer has stepped through
// PC_BACK back to PC_LOAD after the result is loaded into the output register; the
// next set may load while that result waits to be taken.
module median_by_sorting #(
    parameter int unsigned MAX_ITEMS = mbs_pkg::MAX_ITEMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] median
    output logic        m_tuser    // [0] overflowed
);

    localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned KW = CW + 1;

    mbs_pkg::ucode_t      uc;
    mbs_pkg::seq_status_t st;

    mbs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .uc      (uc)
    );

    logic [mbs_pkg::DATA_W-1:0] mem [MAX_ITEMS];

    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [CW-1:0]        n_reg, lim_reg;
    logic                 ovf_set_reg;
    logic [AW-1:0]        k_reg;
    logic signed [31:0]   carry_reg, first_reg, rdata_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          med_reg;
    logic                 ovf_out_reg;

    logic                 beat, full, swap, med_fire;
    logic [KW-1:0]        kk;
    logic [CW-1:0]        mid, lower, lim_m1;
    logic [AW-1:0]        raddr, waddr;
    logic                 we;
    logic [31:0]          wdata;
    logic [32:0]          sum, adj;

    assign s_tready = uc.load_en;
    assign beat     = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(MAX_ITEMS));

    assign kk     = KW'(k_reg) + KW'(2);
    assign mid    = n_reg >> 1;
    assign lower  = n_reg[0] ? mid : CW'(mid - 1'b1);
    assign lim_m1 = CW'(lim_reg - 1'b1);
    assign swap   = carry_reg > rdata_reg;

    assign st.beat_last = beat && s_tlast;
    assign st.lim_lt2   = lim_reg < CW'(2);
    assign st.more      = kk < KW'(lim_reg);
    assign st.out_busy  = m_tvalid_reg && !m_tready;

    assign med_fire = uc.med_out && !st.out_busy;

    always_comb begin
        case (uc.rd_sel)
            mbs_pkg::RD_ZERO:  raddr = '0;
            mbs_pkg::RD_ONE:   raddr = AW'(1);
            mbs_pkg::RD_NEXT:  raddr = kk[AW-1:0];
            mbs_pkg::RD_LOWER: raddr = lower[AW-1:0];
            mbs_pkg::RD_MID:   raddr = mid[AW-1:0];
            default:           raddr = '0;
        endcase
    end

    // one write port shared by loading and the sort passes
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = s_tdata;
        if (beat && !full) begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = s_tdata;
        end else if (uc.sort_step) begin
            we    = 1'b1;
            waddr = k_reg;
            wdata = swap ? rdata_reg : carry_reg;
        end else if (uc.pass_end) begin
            we    = 1'b1;
            waddr = lim_m1[AW-1:0];
            wdata = carry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (beat) begin
            if (s_tlast) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else if (!full) begin
                count_next = CW'(count_reg + 1'b1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    // even count: (a + b) / 2 toward zero; odd count: 2x / 2 = x
    always_comb begin
        sum = n_reg[0] ? {rdata_reg, 1'b0}
                       : ({first_reg[31], first_reg} + {rdata_reg[31], rdata_reg});
        adj = sum + 33'(sum[32]);
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (med_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat && s_tlast) begin
            n_reg       <= full ? count_reg : CW'(count_reg + 1'b1);
            lim_reg     <= full ? count_reg : CW'(count_reg + 1'b1);
            ovf_set_reg <= ovf_reg || full;
        end else if (uc.pass_end) begin
            lim_reg <= lim_m1;
        end
        if (uc.k_clr) begin
            k_reg <= '0;
        end else if (uc.sort_step) begin
            k_reg <= AW'(k_reg + 1'b1);
        end
        if (uc.carry_ld || (uc.sort_step && !swap)) begin
            carry_reg <= rdata_reg;
        end
        if (uc.med_first) begin
            first_reg <= rdata_reg;
        end
        if (med_fire) begin
            med_reg     <= adj[32:1];
            ovf_out_reg <= ovf_set_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = med_reg;
    assign m_tuser  = ovf_out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_close_stops_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && s_tlast) |=> !s_tready)
        else $error("loading continued after closing beat");

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && s_tlast) |=> (count_reg == '0 && !ovf_reg))
        else $error("set not cleared after closing beat");

    a_lim_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (uc.sort_step || uc.pass_end) |-> (lim_reg <= n_reg && lim_reg >= CW'(2)))
        else $error("sort pass limit out of range");

endmodule

### rtl/mbs_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module mbs_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbs_pkg::seq_status_t st,
    output mbs_pkg::ucode_t     uc
);

    mbs_pkg::pc_t pc_reg;
    mbs_pkg::pc_t pc_next;
    logic         take;

    assign uc = mbs_pkg::ucode_rom(pc_reg);

    always_comb begin
        case (uc.jc)
            mbs_pkg::JC_NONE:     take = 1'b0;
            mbs_pkg::JC_ALWAYS:   take = 1'b1;
            mbs_pkg::JC_NOT_LAST: take = !st.beat_last;
            mbs_pkg::JC_LIM_LT2:  take = st.lim_lt2;
            mbs_pkg::JC_MORE:     take = st.more;
            mbs_pkg::JC_OUT_BUSY: take = st.out_busy;
            default:              take = 1'b1;
        endcase
        pc_next = take ? uc.target : mbs_pkg::pc_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= mbs_pkg::PC_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

### test/median_by_sorting_tb.sv
// Self-checking testbench for the median-by-sorting block: directed table, sets around capacity, then random sets.
module median_by_sorting_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_ITEMS   = mbs_pkg::MAX_ITEMS_DEF;
    localparam int          ITEM_BUDGET = 1450;
    localparam int          CALM_FROM   = 1330;
    localparam int          HOLD_AT     = 900;
    localparam int          LONG_HOLD   = 1500;
    localparam int          TAIL_CYCLES = 200;
    localparam int          IDLE_LIMIT  = 60000;
    localparam int          DIR_ROWS    = 20;

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;

    typedef enum int {
        VAL_ANY,
        VAL_SMALL,
        VAL_EDGES
    } val_mode_t;

    typedef struct packed {
        logic [31:0] median;
        logic        ovf;
    } median_res_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        typed;
        logic [31:0] med;
        logic        ovf;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    median_res_t median_fifo[$];
    int          pending_vals[$];
    bit          pending_drop = 1'b0;
    int          mismatch_count = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    dir_row_t    dir_tab [DIR_ROWS];

    median_by_sorting #(.MAX_ITEMS(MAX_ITEMS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] median
        .m_tuser  (m_tuser)    // [0] overflowed
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Collects one element; on the closing element sorts the set and forms its median.
    function automatic void absorb_element(input logic [31:0] value, input bit last,
                                           output bit closed, output median_res_t res);
        int     sorted[$];
        int     n;
        int     key;
        int     j;
        longint pair_sum;
        closed = 1'b0;
        res    = '0;
        if (pending_vals.size() < MAX_ITEMS)
            pending_vals.push_back(int'(value));
        else
            pending_drop = 1'b1;
        if (last) begin
            sorted = pending_vals;
            n = sorted.size();
            for (int i = 1; i < n; i++) begin
                key = sorted[i];
                j   = i - 1;
                while (j >= 0 && sorted[j] > key) begin
                    sorted[j + 1] = sorted[j];
                    j--;
                end
                sorted[j + 1] = key;
            end
            if (n % 2 == 1) begin
                res.median = sorted[n / 2];
            end else begin
                // 33-bit sum, division truncates toward zero
                pair_sum   = longint'(sorted[n / 2 - 1]) + longint'(sorted[n / 2]);
                res.median = 32'(pair_sum / 2);
            end
            res.ovf = pending_drop;
            closed  = 1'b1;
            pending_vals.delete();
            pending_drop = 1'b0;
        end
    endfunction

    function automatic logic [31:0] pick_value(input val_mode_t mode);
        logic [31:0] v;
        case (mode)
            VAL_SMALL: v = 32'($signed($urandom_range(0, 16)) - 8);
            VAL_EDGES: begin
                case ($urandom_range(0, 5))
                    0:       v = INT_MAX;
                    1:       v = INT_MIN;
                    2:       v = INT_MAX - 1;
                    3:       v = INT_MIN + 1;
                    4:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_beat(input logic [31:0] value, input bit last, input bit typed,
                             input median_res_t typed_res);
        bit          closed;
        median_res_t res;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        items_sent++;
        absorb_element(value, last, closed, res);
        if (closed)
            median_fifo.push_back(typed ? typed_res : res);
    endtask

    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        s_tlast  <= 1'($urandom_range(0, 1));
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (median_fifo.size() != 0) @(posedge aclk);
    endtask

    task automatic send_set(input int len, input val_mode_t mode);
        for (int i = 0; i < len; i++) begin
            send_beat(pick_value(mode), i == len - 1, 1'b0, '0);
            if (!calm && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 4));
        end
    endtask

    // Result side: check each beat, then choose next tready (one assignment per edge).
    initial begin
        int          gap_left;
        int          hold_left;
        median_res_t want;
        gap_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (median_fifo.size() == 0) begin
                    $display("%0t: unexpected result beat median=%h ovf=%b",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = median_fifo.pop_front();
                    if (m_tdata !== want.median) begin
                        $display("%0t: median mismatch expected %h actual %h",
                                 $time, want.median, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.ovf) begin
                        $display("%0t: overflowed mismatch expected %b actual %b",
                                 $time, want.ovf, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                    idle_cycles = 0;
                else
                    idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no beat for %0d cycles", $time, idle_cycles);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    initial begin
        int        len;
        val_mode_t mode;
        bit        hold_sent;
        hold_sent = 1'b0;
        dir_tab = '{
            '{INT_MAX,      1'b1, 1'b1, INT_MAX,      1'b0},
            '{INT_MIN,      1'b1, 1'b1, INT_MIN,      1'b0},
            '{INT_MAX,      1'b0, 1'b0, 32'h0,        1'b0},
            '{INT_MAX,      1'b1, 1'b1, INT_MAX,      1'b0},
            '{INT_MIN,      1'b0, 1'b0, 32'h0,        1'b0},
            '{INT_MIN,      1'b1, 1'b1, INT_MIN,      1'b0},
            // max and min: sum is -1, truncates to zero
            '{INT_MAX,      1'b0, 1'b0, 32'h0,        1'b0},
            '{INT_MIN,      1'b1, 1'b1, 32'h0,        1'b0},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,       1'b0},
            '{32'hFFFF_FFFE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
            '{32'd3,        1'b0, 1'b0, 32'h0,        1'b0},
            '{32'd4,        1'b1, 1'b0, 32'h0,        1'b0},
            '{32'd9,        1'b0, 1'b0, 32'h0,        1'b0},
            '{32'd8,        1'b0, 1'b0, 32'h0,        1'b0},
            '{32'd7,        1'b0, 1'b0, 32'h0,        1'b0},
            '{32'd6,        1'b1, 1'b0, 32'h0,        1'b0},
            '{32'd5,        1'b0, 1'b0, 32'h0,        1'b0},
            '{32'hFFFF_FFF9, 1'b0, 1'b0, 32'h0,       1'b0},
            '{32'd0,        1'b1, 1'b0, 32'h0,        1'b0},
            '{32'd0,        1'b1, 1'b1, 32'h0,        1'b0}
        };
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(dir_tab[i].value, dir_tab[i].last, dir_tab[i].typed,
                      {dir_tab[i].med, dir_tab[i].ovf});
            if ($urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 4));
        end
        drain_results();

        // Around capacity: one short, exactly full, last beat dropped, several dropped
        send_set(MAX_ITEMS - 1, VAL_ANY);
        send_set(MAX_ITEMS, VAL_SMALL);
        send_set(MAX_ITEMS + 1, VAL_ANY);
        send_set(MAX_ITEMS + 3, VAL_EDGES);
        drain_results();

        while (items_sent < ITEM_BUDGET) begin
            if (!hold_sent && items_sent >= HOLD_AT) begin
                hold_sent = 1'b1;
                hold_req  = 1'b1;
            end
            if (items_sent >= CALM_FROM)
                calm = 1'b1;
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                               : $urandom_range(1, 16);
            mode = val_mode_t'($urandom_range(0, 2));
            send_set(len, mode);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && median_fifo.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
